FILE: rtl/core/lmot_pkg.sv
// Shared constants and types for the lattice median outlier test.
// No dependencies; used by lmot_median and the top level.
`default_nettype none

package lmot_pkg;

    // Neighbours around one anchor, and bits for a rank among them
    localparam int NBR       = 8;
    localparam int RANK_BITS = 3;

    // Lattice geometry and register field widths
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_BITS     = 12;
    localparam int ROWC_BITS    = 13;
    localparam int WREG_BITS    = 9;
    localparam int HREG_BITS    = 13;
    localparam int TOL_BITS     = 23;
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 32;

    // Register reset values
    localparam int WIDTH_RESET = 2;
    localparam int HEIGHT_RESET = 2;
    localparam int TOL_RESET   = 4096;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_TOL    = 2'd2
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/core/lmot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module lmot_ram #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lmot_median.sv
// Upper median of up to eight flagged values by rank counting, one register stage.
// Depends on lmot_pkg.
`default_nettype none

module lmot_median #(
    parameter int DISP_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [DISP_BITS-1:0] vals [lmot_pkg::NBR],
    input  wire logic                        ok   [lmot_pkg::NBR],
    input  wire logic [lmot_pkg::RANK_BITS-1:0] half,
    output logic signed      [DISP_BITS-1:0] med
);

    logic [lmot_pkg::RANK_BITS-1:0] rank [lmot_pkg::NBR];
    logic [DISP_BITS-1:0]           med_next;
    logic signed [DISP_BITS-1:0]    med_reg;

    // Rank of each valid value; ties broken by slot so ranks are distinct
    always_comb
    begin
        for (int i = 0; i < lmot_pkg::NBR; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < lmot_pkg::NBR; j++)
            begin
                if (j != i && ok[j] &&
                    ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))))
                begin
                    rank[i] = rank[i] + lmot_pkg::RANK_BITS'(1);
                end
            end
        end
    end

    // Pick the value whose rank is n/2
    always_comb
    begin
        med_next = '0;
        for (int i = 0; i < lmot_pkg::NBR; i++)
        begin
            if (ok[i] && rank[i] == half)
            begin
                med_next = med_next | vals[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            med_reg <= signed'(med_next);
        end
    end

    assign med = med_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lattice_median_outlier_test.sv
// Lattice median outlier test: 3x3 upper-median check of anchor displacements.
// A judgement passes stages 1-3 and the output register after the word completing
// its window (one lattice row plus one column later). Throughput: one word per cycle
// unless m_tready stalls, set by the single column RAM read-modify-write in stage 1.
// Reset: rst_n asynchronous, active low; clears counters and valids, loads config registers.
// Depends on lmot_pkg, lmot_ram, lmot_median.
`default_nettype none

module lattice_median_outlier_test #(
    parameter int MAX_LATTICE_WIDTH = 256,
    parameter int DISP_BITS         = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // Input stream
    input  wire logic s_tvalid,
    output logic      s_tready,
    // tdata: anchor_valid, disp_u, disp_v (from bit 0 up), zero padded
    input  wire logic [((1+2*DISP_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: flush
    input  wire logic s_tuser,
    // Result stream
    output logic      m_tvalid,
    input  wire logic m_tready,
    // tdata: lattice_col, lattice_row, keep (from bit 0 up), zero padded
    output logic [(($clog2(MAX_LATTICE_WIDTH)+lmot_pkg::ROW_BITS+1+7)/8)*8-1:0] m_tdata,
    // Configuration port
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [lmot_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [lmot_pkg::PDATA_BITS-1:0] pwdata,
    output logic      [lmot_pkg::PDATA_BITS-1:0] prdata,
    output logic      pready
);

    localparam int CB    = $clog2(MAX_LATTICE_WIDTH);
    localparam int CW1   = CB + 1;
    localparam int CL    = 1 + 2 * DISP_BITS;
    localparam int OUT_F = CB + lmot_pkg::ROW_BITS + 1;
    localparam int OUT_W = ((OUT_F + 7) / 8) * 8;
    localparam int RB    = lmot_pkg::ROWC_BITS;
    localparam int CMPW  = (DISP_BITS + 1 > lmot_pkg::TOL_BITS) ?
                           DISP_BITS + 1 : lmot_pkg::TOL_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    logic [lmot_pkg::WREG_BITS-1:0] width_reg;
    logic [lmot_pkg::HREG_BITS-1:0] height_reg;
    logic [lmot_pkg::TOL_BITS-1:0]  tol_reg;
    logic                           cfg_wr;
    lmot_pkg::reg_idx_t             cfg_idx;
    logic [CW1-1:0]                 w_eff;
    logic [RB-1:0]                  h_eff;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = lmot_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            lmot_pkg::REG_WIDTH:  prdata = lmot_pkg::PDATA_BITS'(width_reg);
            lmot_pkg::REG_HEIGHT: prdata = lmot_pkg::PDATA_BITS'(height_reg);
            lmot_pkg::REG_TOL:    prdata = lmot_pkg::PDATA_BITS'(tol_reg);
            default:              prdata = '0;
        endcase
    end

    // Clamp sizes into their usable range
    always_comb
    begin
        if (width_reg < lmot_pkg::WREG_BITS'(2))
            w_eff = CW1'(2);
        else if (32'(width_reg) > MAX_LATTICE_WIDTH)
            w_eff = CW1'(MAX_LATTICE_WIDTH);
        else
            w_eff = CW1'(width_reg);

        if (height_reg < lmot_pkg::HREG_BITS'(2))
            h_eff = RB'(2);
        else if (32'(height_reg) > lmot_pkg::HEIGHT_LIMIT)
            h_eff = RB'(lmot_pkg::HEIGHT_LIMIT);
        else
            h_eff = RB'(height_reg);
    end

    // ---------------------------------------------------------------
    // Handshake and position counters
    logic           en;
    logic           s_acc;
    logic [CB-1:0]  col_reg;
    logic [RB-1:0]  row_reg;
    logic [CW1-1:0] col_inc;
    logic [CW1-1:0] wm1;
    logic           out_v_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;
    assign s_acc    = s_tvalid && en;
    assign col_inc  = {1'b0, col_reg} + CW1'(1);
    assign wm1      = w_eff - CW1'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lmot_pkg::WREG_BITS'(lmot_pkg::WIDTH_RESET);
            height_reg <= lmot_pkg::HREG_BITS'(lmot_pkg::HEIGHT_RESET);
            tol_reg    <= lmot_pkg::TOL_BITS'(lmot_pkg::TOL_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lmot_pkg::REG_WIDTH:
                begin
                    width_reg <= pwdata[lmot_pkg::WREG_BITS-1:0];
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                lmot_pkg::REG_HEIGHT:
                begin
                    height_reg <= pwdata[lmot_pkg::HREG_BITS-1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                lmot_pkg::REG_TOL:
                begin
                    tol_reg <= pwdata[lmot_pkg::TOL_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (s_acc)
        begin
            if (row_reg >= h_eff + RB'(1))
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= row_reg + RB'(1);
            end
            else
            begin
                col_reg <= col_inc[CB-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: word registered, column RAM read in flight
    logic            v1_reg;
    logic [CL-1:0]   cell1_reg;
    logic [CB-1:0]   col1_reg;
    logic            prod1_reg;
    logic [CB-1:0]   cc1_reg;
    logic [RB-1:0]   cr1_reg;
    logic            mtop1_reg;
    logic            mleft1_reg;
    logic            mright1_reg;
    logic [RB-1:0]   cr_calc;

    assign cr_calc = (col_reg == '0) ? row_reg - RB'(2) : row_reg - RB'(1);

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cell1_reg   <= {s_tdata[CL-1:1],
                            s_tdata[0] && !s_tuser && (row_reg < h_eff)};
            col1_reg    <= col_reg;
            prod1_reg   <= (row_reg >= RB'(2)) || (row_reg == RB'(1) && col_reg != '0);
            cc1_reg     <= (col_reg == '0) ? wm1[CB-1:0] : col_reg - CB'(1);
            cr1_reg     <= cr_calc;
            mtop1_reg   <= (cr_calc == '0);
            mleft1_reg  <= (col_reg == CB'(1));
            mright1_reg <= (col_reg == '0);
        end
    end

    // Column RAM: per column, the cells of the two rows above
    logic [2*CL-1:0] ram_rd;
    logic            st1_go;

    assign st1_go = en && v1_reg;

    lmot_ram #(
        .WIDTH (2 * CL),
        .DEPTH (MAX_LATTICE_WIDTH)
    ) u_colram (
        .clk   (clk),
        .we    (st1_go),
        .waddr (col1_reg),
        .wdata ({ram_rd[CL-1:0], cell1_reg}),
        .re    (s_acc),
        .raddr (col_reg),
        .rdata (ram_rd)
    );

    // Window: two previous columns plus the incoming one (top, mid, bottom)
    logic [CL-1:0] pa_reg [3];
    logic [CL-1:0] pb_reg [3];
    logic [CL-1:0] nc     [3];
    logic [CL-1:0] win    [9];

    assign nc[0] = ram_rd[2*CL-1:CL];
    assign nc[1] = ram_rd[CL-1:0];
    assign nc[2] = cell1_reg;

    always_ff @(posedge clk)
    begin
        if (st1_go)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pa_reg[r] <= pb_reg[r];
                pb_reg[r] <= nc[r];
            end
        end
    end

    // Mask slots outside the lattice
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win[r*3+0] = pa_reg[r];
            win[r*3+1] = pb_reg[r];
            win[r*3+2] = nc[r];
            win[r*3+0][0] = pa_reg[r][0] && !mleft1_reg && !(r == 0 && mtop1_reg);
            win[r*3+1][0] = pb_reg[r][0] && !(r == 0 && mtop1_reg);
            win[r*3+2][0] = nc[r][0] && !mright1_reg && !(r == 0 && mtop1_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: gathered neighbours
    logic                        v2_reg;
    logic signed [DISP_BITS-1:0] nb_u_reg [lmot_pkg::NBR];
    logic signed [DISP_BITS-1:0] nb_v_reg [lmot_pkg::NBR];
    logic                        nb_ok_reg [lmot_pkg::NBR];
    logic [CL-1:0]               c2_reg;
    logic                        prod2_reg;
    logic [CB-1:0]               cc2_reg;
    logic [RB-1:0]               cr2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < lmot_pkg::NBR; k++)
            begin
                nb_ok_reg[k] <= win[(k < 4) ? k : k + 1][0];
                nb_u_reg[k]  <= signed'(win[(k < 4) ? k : k + 1][DISP_BITS:1]);
                nb_v_reg[k]  <= signed'(win[(k < 4) ? k : k + 1][2*DISP_BITS:DISP_BITS+1]);
            end
            c2_reg    <= win[4];
            prod2_reg <= prod1_reg;
            cc2_reg   <= cc1_reg;
            cr2_reg   <= cr1_reg;
        end
    end

    logic [3:0] n2;

    always_comb
    begin
        n2 = '0;
        for (int k = 0; k < lmot_pkg::NBR; k++)
        begin
            n2 = n2 + 4'(nb_ok_reg[k]);
        end
    end

    logic signed [DISP_BITS-1:0] med_u;
    logic signed [DISP_BITS-1:0] med_v;

    lmot_median #(
        .DISP_BITS (DISP_BITS)
    ) u_med_u (
        .clk  (clk),
        .en   (en),
        .vals (nb_u_reg),
        .ok   (nb_ok_reg),
        .half (n2[3:1]),
        .med  (med_u)
    );

    lmot_median #(
        .DISP_BITS (DISP_BITS)
    ) u_med_v (
        .clk  (clk),
        .en   (en),
        .vals (nb_v_reg),
        .ok   (nb_ok_reg),
        .half (n2[3:1]),
        .med  (med_v)
    );

    // ---------------------------------------------------------------
    // Stage 3: medians ready, deviation test
    logic          v3_reg;
    logic [CL-1:0] c3_reg;
    logic          few3_reg;
    logic          prod3_reg;
    logic [CB-1:0] cc3_reg;
    logic [RB-1:0] cr3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg    <= c2_reg;
            few3_reg  <= (n2 < 4'd3);
            prod3_reg <= prod2_reg;
            cc3_reg   <= cc2_reg;
            cr3_reg   <= cr2_reg;
        end
    end

    logic signed [DISP_BITS:0] du;
    logic signed [DISP_BITS:0] dv;
    logic        [DISP_BITS:0] au;
    logic        [DISP_BITS:0] av;
    logic                      keep3;

    assign du = {c3_reg[DISP_BITS], c3_reg[DISP_BITS:1]} - {med_u[DISP_BITS-1], med_u};
    assign dv = {c3_reg[2*DISP_BITS], c3_reg[2*DISP_BITS:DISP_BITS+1]} -
                {med_v[DISP_BITS-1], med_v};
    assign au = du[DISP_BITS] ? -du : du;
    assign av = dv[DISP_BITS] ? -dv : dv;
    assign keep3 = c3_reg[0] &&
                   (few3_reg || ((CMPW'(au) <= CMPW'(tol_reg)) &&
                                 (CMPW'(av) <= CMPW'(tol_reg))));

    // ---------------------------------------------------------------
    // Output register
    logic [OUT_F-1:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {keep3, cr3_reg[lmot_pkg::ROW_BITS-1:0], cc3_reg};
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= v3_reg && prod3_reg;
        end
    end

    // v2 only feeds the chain; prod flags decide which words become results
    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_W'(out_reg);

endmodule

`default_nettype wire
